// File: rtl/core/crgc_pkg.sv
`default_nettype none
package crgc_pkg;

  localparam logic [31:0] MAGIC_VALUE  = 32'h4A52_4443;
  localparam logic [15:0] FORMAT_VALUE = 16'h0001;
  localparam logic [31:0] CRC_POLY     = 32'hEDB8_8320;
  localparam logic [31:0] ALL_ONES     = 32'hFFFF_FFFF;
  localparam logic [4:0]  HDR_LAST     = 5'd23;
  localparam logic [4:0]  HDR_BYTES    = 5'd24;

  typedef enum logic [1:0] {
    OUT_HIT   = 2'd0,
    OUT_MISS  = 2'd1,
    OUT_ERROR = 2'd2
  } outcome_t;

  typedef struct packed {
    logic        valid;
    outcome_t    outcome;
    logic [31:0] firmware_version;
    logic [15:0] device_crc;
    logic [31:0] payload_length;
  } result_t;

  // Reflected CRC-32 advanced by one byte.
  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? (CRC_POLY ^ (c >> 1)) : (c >> 1);
    end
    return c;
  endfunction

endpackage
`default_nettype wire

// File: rtl/core/crc_guarded_record_checker.sv
`default_nettype none
// Channel  Direction  Handshake               Contents
// in_      slave      in_tvalid / in_tready   one record byte, tlast marks end of stream
// out_     master     out_tvalid / out_tready one verdict word per record
// cfg_     APB        psel/penable, pready=1  expected firmware at address 0
//
// One byte word is taken per cycle when the verdict side is not stalled.
// A byte is held in the input register until it is processed, and its verdict, if any,
// appears on out_ in the cycle after it is processed.
// The CRC byte step and the 32-bit payload count compare set the cycle time.
// Reset is synchronous and returns the checker to the start of a record.
// A stalled verdict holds the input register, which then deasserts in_tready.
module crc_guarded_record_checker (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] data_byte
  input  wire logic        in_tlast,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [87:0]      out_tdata,  // [1:0] outcome, [33:2] firmware_version,
                                       // [49:34] device_crc, [81:50] payload_length, zero pad
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [2:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);

  logic              in_valid_r;
  logic [7:0]        in_data_r;
  logic              in_last_r;
  logic              out_valid_r;
  logic [87:0]       out_data_r;
  logic              fire;
  logic [31:0]       expected_fw;
  crgc_pkg::result_t res;

  crgc_regs u_regs (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .expected_fw (expected_fw)
  );

  crgc_check u_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (fire),
    .data_byte   (in_data_r),
    .eos         (in_last_r),
    .expected_fw (expected_fw),
    .res         (res)
  );

  assign fire       = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready  = !in_valid_r || fire;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_tready) begin
        in_valid_r <= in_tvalid;
      end
      if (!out_valid_r || out_tready) begin
        out_valid_r <= fire && res.valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_data_r <= in_tdata;
      in_last_r <= in_tlast;
    end
    if (fire && res.valid) begin
      out_data_r <= {6'd0, res.payload_length, res.device_crc,
                     res.firmware_version, res.outcome};
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/crgc_regs.sv
`default_nettype none
module crgc_regs (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [2:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready,
  output logic [31:0]      expected_fw
);

  logic [31:0] expected_fw_r;
  logic        wr_en;

  assign cfg_pready  = 1'b1;
  assign wr_en       = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata  = (cfg_paddr[2] == 1'b0) ? expected_fw_r : 32'd0;
  assign expected_fw = expected_fw_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      expected_fw_r <= 32'd0;
    end else if (wr_en && cfg_paddr[2] == 1'b0) begin
      expected_fw_r <= cfg_pwdata;
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/crgc_check.sv
`default_nettype none
module crgc_check (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        step,
  input  wire logic [7:0]  data_byte,
  input  wire logic        eos,
  input  wire logic [31:0] expected_fw,
  output crgc_pkg::result_t res
);

  logic [4:0]  hdr_pos_r, hdr_pos_nxt;
  logic [31:0] crc_r, crc_nxt;
  logic [31:0] count_r, count_nxt;
  logic        verdict_r, verdict_nxt;

  logic [31:0] magic_r, magic_nxt;
  logic [15:0] format_r, format_nxt;
  logic [15:0] dcrc_r, dcrc_nxt;
  logic [31:0] fw_r, fw_nxt;
  logic [31:0] len_r, len_nxt;
  logic [31:0] stored_crc_r, stored_crc_nxt;

  logic                emit;
  crgc_pkg::outcome_t  outcome;
  logic [31:0]         crc_step;
  logic [4:0]          lane32;
  logic [3:0]          lane16;

  assign crc_step = crgc_pkg::crc_byte(crc_r, data_byte);
  assign lane32   = {hdr_pos_r[1:0], 3'b000};
  assign lane16   = {hdr_pos_r[0], 3'b000};

  always_comb begin
    hdr_pos_nxt    = hdr_pos_r;
    crc_nxt        = crc_r;
    count_nxt      = count_r;
    verdict_nxt    = verdict_r;
    magic_nxt      = magic_r;
    format_nxt     = format_r;
    dcrc_nxt       = dcrc_r;
    fw_nxt         = fw_r;
    len_nxt        = len_r;
    stored_crc_nxt = stored_crc_r;
    emit           = 1'b0;
    outcome        = crgc_pkg::OUT_ERROR;

    if (verdict_r) begin
      emit = 1'b0;
    end else if (hdr_pos_r < crgc_pkg::HDR_BYTES) begin
      if (hdr_pos_r < 5'd4) begin
        magic_nxt[lane32 +: 8] = data_byte;
      end else if (hdr_pos_r < 5'd6) begin
        format_nxt[lane16 +: 8] = data_byte;
      end else if (hdr_pos_r < 5'd8) begin
        dcrc_nxt[lane16 +: 8] = data_byte;
      end else if (hdr_pos_r < 5'd12) begin
        fw_nxt[lane32 +: 8] = data_byte;
      end else if (hdr_pos_r < 5'd16) begin
        fw_nxt = fw_r;
      end else if (hdr_pos_r < 5'd20) begin
        len_nxt[lane32 +: 8] = data_byte;
      end else begin
        stored_crc_nxt[lane32 +: 8] = data_byte;
      end
      hdr_pos_nxt = hdr_pos_r + 5'd1;

      if (hdr_pos_r == crgc_pkg::HDR_LAST) begin
        if (magic_nxt != crgc_pkg::MAGIC_VALUE || format_nxt != crgc_pkg::FORMAT_VALUE) begin
          emit    = 1'b1;
          outcome = crgc_pkg::OUT_ERROR;
        end else if (expected_fw != 32'd0 && fw_nxt != expected_fw) begin
          emit    = 1'b1;
          outcome = crgc_pkg::OUT_MISS;
        end else if (len_nxt == 32'd0) begin
          emit    = 1'b1;
          outcome = ((crc_r ^ crgc_pkg::ALL_ONES) == stored_crc_nxt) ?
                    crgc_pkg::OUT_HIT : crgc_pkg::OUT_ERROR;
        end else if (eos) begin
          emit    = 1'b1;
          outcome = crgc_pkg::OUT_ERROR;
        end
      end else if (eos) begin
        emit    = 1'b1;
        outcome = crgc_pkg::OUT_ERROR;
      end
    end else begin
      crc_nxt   = crc_step;
      count_nxt = count_r + 32'd1;
      if (count_nxt >= len_r) begin
        emit    = 1'b1;
        outcome = ((crc_step ^ crgc_pkg::ALL_ONES) == stored_crc_r) ?
                  crgc_pkg::OUT_HIT : crgc_pkg::OUT_ERROR;
      end else if (eos) begin
        emit    = 1'b1;
        outcome = crgc_pkg::OUT_ERROR;
      end
    end

    if (emit) begin
      verdict_nxt = 1'b1;
    end
    if (eos) begin
      hdr_pos_nxt = 5'd0;
      crc_nxt     = crgc_pkg::ALL_ONES;
      count_nxt   = 32'd0;
      verdict_nxt = 1'b0;
    end
  end

  always_comb begin
    res.valid   = emit;
    res.outcome = outcome;
    if (outcome == crgc_pkg::OUT_HIT) begin
      res.firmware_version = fw_nxt;
      res.device_crc       = dcrc_nxt;
      res.payload_length   = len_nxt;
    end else begin
      res.firmware_version = 32'd0;
      res.device_crc       = 16'd0;
      res.payload_length   = 32'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hdr_pos_r <= 5'd0;
      crc_r     <= crgc_pkg::ALL_ONES;
      count_r   <= 32'd0;
      verdict_r <= 1'b0;
    end else if (step) begin
      hdr_pos_r <= hdr_pos_nxt;
      crc_r     <= crc_nxt;
      count_r   <= count_nxt;
      verdict_r <= verdict_nxt;
    end
  end

  // Header fields are always fully rewritten before they are judged.
  always_ff @(posedge clk) begin
    if (step) begin
      magic_r      <= magic_nxt;
      format_r     <= format_nxt;
      dcrc_r       <= dcrc_nxt;
      fw_r         <= fw_nxt;
      len_r        <= len_nxt;
      stored_crc_r <= stored_crc_nxt;
    end
  end

endmodule
`default_nettype wire
